// File: sv/integer_to_ascii_radix_defines.svh
// Assertion macros for the radix conversion block.
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define ITOA_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error(msg);

`define ITOA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error(msg);

`else

`define ITOA_ASSERT_IMPLY(label, clk, rst, lhs, rhs, msg)

`define ITOA_ASSERT_NEXT(label, clk, rst, lhs, rhs, msg)

`endif

`endif

// File: sv/itoa_pkg.sv
package itoa_pkg;

   localparam int VALUE_W       = 32;
   localparam int RADIX_W       = 6;
   localparam int CHAR_W        = 7;
   localparam int MAX_DIGITS    = 32;
   localparam int ADDR_W        = $clog2(MAX_DIGITS);
   localparam int CNT_W         = $clog2(MAX_DIGITS + 1);
   localparam int BITS_PER_STEP = 8;
   localparam int STEP_COUNT    = VALUE_W / BITS_PER_STEP;
   localparam int STEP_W        = $clog2(STEP_COUNT);

   localparam int CSR_ADDR_W    = 1;
   localparam int CSR_DATA_W    = 6;

   localparam logic [CSR_ADDR_W-1:0] CSR_RADIX      = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MAX_DIGITS = 1'd1;

   localparam logic [RADIX_W-1:0] RADIX_RESET     = 6'd10;
   localparam logic [RADIX_W-1:0] RADIX_MIN       = 6'd2;
   localparam logic [RADIX_W-1:0] RADIX_MAX       = 6'd36;
   localparam logic [RADIX_W-1:0] RADIX_SIGN_MAX  = 6'd10;
   localparam logic [CNT_W-1:0]   LIMIT_RESET     = CNT_W'(MAX_DIGITS);
   localparam logic [CNT_W-1:0]   LIMIT_MIN       = CNT_W'(1);
   localparam logic [CNT_W-1:0]   LIMIT_MAX       = CNT_W'(MAX_DIGITS);

   localparam logic [CHAR_W-1:0]  ASCII_ZERO      = 7'h30;
   localparam logic [CHAR_W-1:0]  ASCII_A         = 7'h41;
   localparam logic [CHAR_W-1:0]  ASCII_MINUS     = 7'h2D;
   localparam logic [RADIX_W-1:0] DECIMAL_DIGITS  = 6'd10;

   typedef struct packed {
      logic load;
      logic step;
      logic pop;
      logic show_sign;
   } ctrl_cmd_type;

   typedef struct packed {
      logic conv_done;
      logic negative;
      logic last_digit;
   } dp_status_type;

   function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
      if (d < DECIMAL_DIGITS) begin
         return ASCII_ZERO + CHAR_W'(d);
      end
      return ASCII_A + CHAR_W'(d - DECIMAL_DIGITS);
   endfunction

endpackage

// File: sv/itoa_ctrl.sv
module itoa_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  itoa_pkg::dp_status_type status,
   output itoa_pkg::ctrl_cmd_type  cmd,
   output logic                   rsp_valid,
   output logic                   rsp_last
);
   import itoa_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SIGN,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      last_ff, last_in;
   logic      sign_ff, sign_in;

   always_comb begin
      state_in = state_ff;
      valid_in = 1'b0;
      last_in  = 1'b0;
      sign_in  = 1'b0;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.conv_done) begin
               state_in = status.negative ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            valid_in = 1'b1;
            sign_in  = 1'b1;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.pop  = 1'b1;
            valid_in = 1'b1;
            last_in  = status.last_digit;
            if (status.last_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      cmd.show_sign = sign_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
         sign_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
         sign_ff  <= sign_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_last  = last_ff;

endmodule

// File: sv/itoa_dpath.sv
module itoa_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  itoa_pkg::ctrl_cmd_type              cmd,
   output itoa_pkg::dp_status_type             status,
   input  logic                                req_kind,
   input  logic [itoa_pkg::VALUE_W-1:0]        req_value,
   input  logic                                csr_write_enable,
   input  logic [itoa_pkg::CSR_ADDR_W-1:0]     csr_index,
   input  logic [itoa_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic [itoa_pkg::CHAR_W-1:0]         rsp_char_code
);
   import itoa_pkg::*;

   logic [RADIX_W-1:0] radix_ff;
   logic [CNT_W-1:0]   max_digits_ff;

   logic [RADIX_W-1:0] base_ff, base_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic               neg_ff, neg_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic [RADIX_W-1:0] rem_ff, rem_in;
   logic [STEP_W-1:0]  step_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [RADIX_W-1:0] rd_ff;

   logic [RADIX_W-1:0] digit_stack_ff [MAX_DIGITS];

   logic               step_last;
   logic [CNT_W-1:0]   cnt_inc;
   logic [CNT_W-1:0]   cnt_dec;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff      <= RADIX_RESET;
         max_digits_ff <= LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_RADIX:      radix_ff      <= csr_write_data[RADIX_W-1:0];
            CSR_MAX_DIGITS: max_digits_ff <= CNT_W'(csr_write_data);
            default: begin
            end
         endcase
      end
   end

   // clamp settings and decide whether the value is negative
   always_comb begin
      if (radix_ff < RADIX_MIN) begin
         base_in = RADIX_MIN;
      end else if (radix_ff > RADIX_MAX) begin
         base_in = RADIX_MAX;
      end else begin
         base_in = radix_ff;
      end
      if (max_digits_ff < LIMIT_MIN) begin
         limit_in = LIMIT_MIN;
      end else if (max_digits_ff > LIMIT_MAX) begin
         limit_in = LIMIT_MAX;
      end else begin
         limit_in = max_digits_ff;
      end
      neg_in = !req_kind && req_value[VALUE_W-1] && (base_in <= RADIX_SIGN_MAX);
   end

   // one slice of restoring division: BITS_PER_STEP quotient bits per cycle
   always_comb begin
      logic [RADIX_W:0]         r;
      logic [BITS_PER_STEP-1:0] qb;
      r  = {1'b0, rem_ff};
      qb = '0;
      for (int j = 0; j < BITS_PER_STEP; j++) begin
         r = {r[RADIX_W-1:0], mag_ff[VALUE_W-1-j]};
         if (r >= {1'b0, base_ff}) begin
            r = r - {1'b0, base_ff};
            qb[BITS_PER_STEP-1-j] = 1'b1;
         end
      end
      rem_in = r[RADIX_W-1:0];
      mag_in = {mag_ff[VALUE_W-BITS_PER_STEP-1:0], qb};
   end

   assign step_last = (step_ff == STEP_W'(STEP_COUNT - 1));
   assign cnt_inc   = cnt_ff + CNT_W'(1);
   assign cnt_dec   = cnt_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.load) begin
         step_ff <= '0;
         cnt_ff  <= '0;
      end else if (cmd.step) begin
         step_ff <= step_ff + STEP_W'(1);
         if (step_last) begin
            cnt_ff <= cnt_inc;
         end
      end else if (cmd.pop) begin
         cnt_ff <= cnt_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         base_ff  <= base_in;
         limit_ff <= limit_in;
         neg_ff   <= neg_in;
         mag_ff   <= neg_in ? (VALUE_W'(0) - req_value) : req_value;
         rem_ff   <= '0;
      end else if (cmd.step) begin
         mag_ff <= mag_in;
         rem_ff <= step_last ? '0 : rem_in;
      end
   end

   // digit stack
   always_ff @(posedge clock) begin
      if (cmd.step && step_last) begin
         digit_stack_ff[cnt_ff[ADDR_W-1:0]] <= rem_in;
      end
      if (cmd.pop) begin
         rd_ff <= digit_stack_ff[cnt_dec[ADDR_W-1:0]];
      end
   end

   assign status.conv_done  = step_last && ((mag_in == '0) || (cnt_inc >= limit_ff));
   assign status.negative   = neg_ff;
   assign status.last_digit = (cnt_ff == CNT_W'(1));

   assign rsp_char_code = cmd.show_sign ? ASCII_MINUS : digit_char(rd_ff);

endmodule

// File: sv/integer_to_ascii_radix.sv
// Channel     Handshake              Payload
// ----------  ---------------------  ---------------------------------------
// request     start, busy            req_kind, req_value
// response    rsp_valid (strobe)     rsp_char_code, rsp_last
// csr         csr_write_enable       csr_index, csr_write_data
//
// An item is taken when start is high and busy is low. Each digit is worked
// out in the shared 8-bit-per-cycle divider, then each character is read
// out of the digit stack: busy stays high until the last digit is popped,
// and the last character shows in the first idle cycle, when the next item
// may already be taken. Reset is synchronous and restores radix 10 and a
// 32-digit limit. Characters cannot be stalled.
`include "integer_to_ascii_radix_defines.svh"

module integer_to_ascii_radix (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_kind,
   input  logic [itoa_pkg::VALUE_W-1:0]     req_value,
   output logic                             rsp_valid,
   output logic [itoa_pkg::CHAR_W-1:0]      rsp_char_code,
   output logic                             rsp_last,
   input  logic                             csr_write_enable,
   input  logic [itoa_pkg::CSR_ADDR_W-1:0]  csr_index,
   input  logic [itoa_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import itoa_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   itoa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .status    (status),
      .cmd       (cmd),
      .rsp_valid (rsp_valid),
      .rsp_last  (rsp_last)
   );

   itoa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_kind         (req_kind),
      .req_value        (req_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_char_code    (rsp_char_code)
   );

   `ITOA_ASSERT_IMPLY(a_last_ends_item, clock, reset, rsp_valid && rsp_last, !busy, "last character while still busy")
   `ITOA_ASSERT_IMPLY(a_result_from_work, clock, reset, rsp_valid, $past(busy), "character without conversion in progress")
   `ITOA_ASSERT_NEXT(a_start_takes, clock, reset, start && !busy, busy, "accepted item did not start conversion")
   `ITOA_ASSERT_NEXT(a_sign_then_digit, clock, reset, rsp_valid && cmd.show_sign, rsp_valid && !cmd.show_sign, "sign not followed by a digit")

endmodule
